FILE: design/gfvc_pkg.sv
package gfvc_pkg;

  localparam int MAX_BITS    = 64;
  localparam int ROW_CAP     = 32;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 6;
  localparam int DIG_W       = 4;
  localparam int CONST_W     = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int OUT_DATA_W  = 72;

  localparam logic [MAX_BITS-1:0] MOD_RESET = 64'd27;

  typedef logic [MAX_BITS-1:0] gf_word_t;

  // Control tag of the item at the head of the queue.
  typedef struct packed {
    logic valid;
    logic last;
  } item_tag_t;

  function automatic gf_word_t gf_mask(int kk);
    return ((gf_word_t'(1) << (kk - 1)) << 1) - gf_word_t'(1);
  endfunction

  // One Horner step, most significant multiplier bit first: r = r*x + bit*a.
  function automatic gf_word_t gf_step(gf_word_t r, gf_word_t a, gf_word_t m,
                                       logic bit_in, int kk);
    gf_word_t x;
    logic     top;
    top = r[kk-1];
    x   = (r << 1) & gf_mask(kk);
    if (top) x = x ^ m;
    if (bit_in) x = x ^ a;
    return x;
  endfunction

  function automatic gf_word_t gf_step_digit(gf_word_t r, gf_word_t a, gf_word_t m,
                                             logic [DIG_W-1:0] d, int kk);
    gf_word_t x;
    x = r;
    for (int b = DIG_W - 1; b >= 0; b--) begin
      x = gf_step(x, a, m, d[b], kk);
    end
    return x;
  endfunction

  // Reduces a row constant (at most CONST_W bits) into the field.
  function automatic gf_word_t gf_reduce_row(gf_word_t x_in, gf_word_t m, int kk);
    gf_word_t x;
    x = x_in;
    for (int i = CONST_W - 1; i >= 0; i--) begin
      if (i >= kk && x[i]) begin
        x[i] = 1'b0;
        x    = x ^ (m << (i - kk));
      end
    end
    return x & gf_mask(kk);
  endfunction

  // Multiplies a reduced element by a small constant.
  function automatic gf_word_t gf_mul_const(gf_word_t p, gf_word_t m,
                                            logic [CONST_W-1:0] c, int kk);
    gf_word_t r;
    r = '0;
    for (int i = CONST_W - 1; i >= 0; i--) begin
      r = gf_step(r, p, m, c[i], kk);
    end
    return r;
  endfunction

endpackage

FILE: design/gf2k_vandermonde_combiner.sv
// Vandermonde row sums over GF(2^k) for one sample of shares.
// Input stream (in_*): one field element per item, in_tlast on the final
// element of a sample. Output stream (out_*): after a flagged element, the
// block gives one item per output row, rows 0 to R-1 in order, R being
// NUM_PARTIES - THRESHOLD held to 0..32; out_tlast marks row R-1. The cfg_*
// channel writes the reduction polynomial without its leading term; it is
// always ready and should be written only while the block is empty.
// Throughput: one element per cycle while in_tready is high. A flagged
// element passes the queue, the multiplier lanes (four multiplier bits
// per stage) and the row buffer. Its rows leave at one per cycle while
// out_tready is high; the next rows load as the last one is taken.
// A four-entry queue separates input acceptance from the multiplier lanes.
// When the receiver stalls, the row buffer holds; a following flagged element
// then halts the lanes at their exit, the queue fills and in_tready falls.
// Reset (rst_n low, synchronous) empties the queue and the lanes, clears all
// sums, restarts every row power at j+1 and sets the polynomial to 27.
module gf2k_vandermonde_combiner #(
  parameter int NUM_PARTIES = 8,
  parameter int THRESHOLD   = 3,
  parameter int FIELD_BITS  = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gfvc_pkg::MAX_BITS-1:0]     in_tdata,   // [63:0] share_value
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [63:0] combo_value, [68:64] combo_index, [71:69] zero
  output logic [gfvc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gfvc_pkg::MAX_BITS-1:0]     cfg_data
);
  import gfvc_pkg::*;

  localparam int ROWS_RAW = NUM_PARTIES - THRESHOLD;
  localparam int ROWS     = (ROWS_RAW < 0) ? 0 : ((ROWS_RAW > ROW_CAP) ? ROW_CAP : ROWS_RAW);
  localparam int ROWS_D   = (ROWS < 1) ? 1 : ROWS;
  localparam int K        = (FIELD_BITS < 2) ? 2
                          : ((FIELD_BITS > MAX_BITS) ? MAX_BITS : FIELD_BITS);
  localparam int NSTG     = (K + DIG_W - 1) / DIG_W;

  logic [K-1:0]              mod_r;
  item_tag_t                 head_tag;
  logic [K-1:0]              head_share;
  logic                      pop;
  logic                      can_load;
  logic                      load;
  logic [ROWS_D-1:0][K-1:0]  load_vals;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MOD_RESET[K-1:0];
    end else if (cfg_valid) begin
      mod_r <= cfg_data[K-1:0];
    end
  end

  gfvc_front #(
    .K (K)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .pop        (pop),
    .head_tag   (head_tag),
    .head_share (head_share)
  );

  gfvc_back #(
    .K      (K),
    .ROWS   (ROWS),
    .ROWS_D (ROWS_D),
    .NSTG   (NSTG)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_tag   (head_tag),
    .head_share (head_share),
    .pop        (pop),
    .modulus    (mod_r),
    .can_load   (can_load),
    .load       (load),
    .load_vals  (load_vals)
  );

  gfvc_emit #(
    .K      (K),
    .ROWS   (ROWS),
    .ROWS_D (ROWS_D)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_vals  (load_vals),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("row buffer loaded while rows of the previous sample remain");

  a_last_on_final_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[68:64] == IDX_W'(ROWS - 1))))
    else $error("last flag does not match the final row index");

  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_tag.valid)
    else $error("lanes took an item from an empty queue");

endmodule

FILE: design/gfvc_front.sv
module gfvc_front #(
  parameter int K = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [gfvc_pkg::MAX_BITS-1:0] in_tdata,
  input  logic                          in_tlast,
  input  logic                          pop,
  output gfvc_pkg::item_tag_t           head_tag,
  output logic [K-1:0]                  head_share
);
  import gfvc_pkg::*;

  logic [K-1:0]             share_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   last_q;
  logic [QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]        cnt_r, cnt_nxt;
  logic                     push;
  logic                     do_pop;

  assign in_tready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign do_pop    = pop && (cnt_r != '0);

  assign wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
  assign rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
  assign cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);

  assign head_tag.valid = (cnt_r != '0);
  assign head_tag.last  = last_q[rd_ptr_r];
  assign head_share     = share_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Share bits at and above the field width are dropped on entry.
  always_ff @(posedge clk) begin
    if (push) begin
      share_q[wr_ptr_r] <= in_tdata[K-1:0];
      last_q[wr_ptr_r]  <= in_tlast;
    end
  end

endmodule

FILE: design/gfvc_lane.sv
module gfvc_lane #(
  parameter int K    = 64,
  parameter int NSTG = 16,
  parameter int ROW  = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  pop,
  input  logic                                  pop_last,
  input  logic                                  exit_upd,
  input  logic                                  exit_last,
  input  logic [K-1:0]                          modulus,
  input  logic [NSTG:1][gfvc_pkg::DIG_W-1:0]    dig,
  output logic [K-1:0]                          acc_fin
);
  import gfvc_pkg::*;

  localparam logic [CONST_W-1:0] ROW_CONST = CONST_W'(ROW + 1);

  logic                      fresh_r;
  logic [K-1:0]              p_r;
  logic [K-1:0]              p_eff;
  logic [K-1:0]              p_nxt;
  logic [NSTG-1:0][K-1:0]    a_r;
  logic [NSTG:1][K-1:0]      r_r;
  logic [NSTG:1][K-1:0]      r_nxt;
  logic [K-1:0]              acc_r;

  // A fresh row holds the constant j+1, which may need reducing in a narrow field.
  assign p_eff = fresh_r
               ? K'(gf_reduce_row(gf_word_t'(ROW_CONST), gf_word_t'(modulus), K))
               : p_r;
  assign p_nxt = K'(gf_mul_const(gf_word_t'(p_eff), gf_word_t'(modulus), ROW_CONST, K));

  for (genvar t = 1; t <= NSTG; t++) begin : g_stage
    if (t == 1) begin : g_first
      assign r_nxt[t] = K'(gf_step_digit(gf_word_t'(0), gf_word_t'(a_r[t-1]),
                                         gf_word_t'(modulus), dig[t], K));
    end else begin : g_next
      assign r_nxt[t] = K'(gf_step_digit(gf_word_t'(r_r[t-1]), gf_word_t'(a_r[t-1]),
                                         gf_word_t'(modulus), dig[t], K));
    end
  end

  assign acc_fin = acc_r ^ r_r[NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= 1'b1;
      acc_r   <= '0;
    end else begin
      if (pop) fresh_r <= pop_last;
      if (exit_upd) acc_r <= exit_last ? '0 : acc_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !pop_last) p_r <= p_nxt;
    if (adv) begin
      a_r[0] <= p_eff;
      for (int t = 1; t < NSTG; t++) begin
        a_r[t] <= a_r[t-1];
      end
      for (int t = 1; t <= NSTG; t++) begin
        r_r[t] <= r_nxt[t];
      end
    end
  end

endmodule

FILE: design/gfvc_back.sv
module gfvc_back #(
  parameter int K      = 64,
  parameter int ROWS   = 5,
  parameter int ROWS_D = 5,
  parameter int NSTG   = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gfvc_pkg::item_tag_t         head_tag,
  input  logic [K-1:0]                head_share,
  output logic                        pop,
  input  logic [K-1:0]                modulus,
  input  logic                        can_load,
  output logic                        load,
  output logic [ROWS_D-1:0][K-1:0]    load_vals
);
  import gfvc_pkg::*;

  localparam int SP = NSTG * DIG_W;

  logic [NSTG:0]               v_r;
  logic [NSTG:0]               last_r;
  logic [SP-1:0]               s_r [NSTG];
  logic [NSTG:1][DIG_W-1:0]    dig;
  logic                        adv;
  logic                        exit_upd;
  logic                        exit_last;

  // The whole pipeline holds while a finished sample waits for the row buffer.
  assign adv       = !(v_r[NSTG] && last_r[NSTG] && !can_load);
  assign pop       = adv && head_tag.valid;
  assign exit_upd  = adv && v_r[NSTG];
  assign exit_last = exit_upd && last_r[NSTG];
  assign load      = (ROWS != 0) && exit_last;

  for (genvar t = 1; t <= NSTG; t++) begin : g_dig
    assign dig[t] = s_r[t-1][(NSTG-t)*DIG_W +: DIG_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-1:0], head_tag.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_r <= {last_r[NSTG-1:0], head_tag.last};
      s_r[0] <= SP'(head_share);
      for (int t = 1; t < NSTG; t++) begin
        s_r[t] <= s_r[t-1];
      end
    end
  end

  for (genvar j = 0; j < ROWS_D; j++) begin : g_row
    gfvc_lane #(
      .K    (K),
      .NSTG (NSTG),
      .ROW  (j)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .pop       (pop),
      .pop_last  (head_tag.last),
      .exit_upd  (exit_upd),
      .exit_last (exit_last),
      .modulus   (modulus),
      .dig       (dig),
      .acc_fin   (load_vals[j])
    );
  end

endmodule

FILE: design/gfvc_emit.sv
module gfvc_emit #(
  parameter int K      = 64,
  parameter int ROWS   = 5,
  parameter int ROWS_D = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic [ROWS_D-1:0][K-1:0]          load_vals,
  output logic                              can_load,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gfvc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);
  import gfvc_pkg::*;

  logic [ROWS_D-1:0][K-1:0]  vals_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      take;
  logic [IDX_W-1:0]          idx;

  assign out_tvalid = (cnt_r != '0);
  assign take       = out_tvalid && out_tready;
  assign can_load   = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_tready);
  assign out_tlast  = (cnt_r == CNT_W'(1));
  assign idx        = IDX_W'(CNT_W'(ROWS) - cnt_r);
  assign out_tdata  = {(OUT_DATA_W - MAX_BITS - IDX_W)'(0), idx, MAX_BITS'(vals_r[0])};

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = CNT_W'(ROWS);
    end else if (take) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Row 0 of the buffer is the output register; rows move down as they are taken.
  always_ff @(posedge clk) begin
    if (load) begin
      vals_r <= load_vals;
    end else if (take) begin
      for (int i = 0; i < ROWS_D - 1; i++) begin
        vals_r[i] <= vals_r[i+1];
      end
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  import gfvc_pkg::*;

  localparam int NUM_PARTIES = 8;
  localparam int THRESHOLD   = 3;
  localparam int FIELD_BITS  = 64;

  localparam int ROWS_RAW = NUM_PARTIES - THRESHOLD;
  localparam int ROWS     = (ROWS_RAW < 0) ? 0 : (ROWS_RAW > ROW_CAP) ? ROW_CAP : ROWS_RAW;
  localparam int K        = (FIELD_BITS < 2) ? 2 : (FIELD_BITS > 64) ? 64 : FIELD_BITS;

  // Enough for the lanes and the input queue to empty after the last row has left.
  localparam int LANE_SLACK = (FIELD_BITS + 3) / 4 + 2 + QUEUE_DEPTH + 16;
  localparam int LONG_HOLD  = 300;

  typedef struct packed {
    logic [63:0] value;
    logic [4:0]  index;
    logic        last;
  } row_sum_t;

  typedef struct packed {
    logic [63:0]      share;
    logic             last;
    logic             fixed;
    logic [4:0][63:0] sums;
  } share_row_t;

  localparam logic [4:0][63:0] ZERO_SUMS = '0;
  // One element of value 1: each row gives its own constant j+1.
  localparam logic [4:0][63:0] ONES_UP   = {64'd5, 64'd4, 64'd3, 64'd2, 64'd1};
  // Elements 0 then 1: each row gives the square of j+1, free of reduction.
  localparam logic [4:0][63:0] SQUARES   = {64'd17, 64'd16, 64'd5, 64'd4, 64'd1};

  localparam share_row_t PLAN [20] = '{
    '{64'd1,                   1'b1, 1'b1, ONES_UP},
    '{64'd0,                   1'b1, 1'b1, ZERO_SUMS},
    '{64'd0,                   1'b0, 1'b0, ZERO_SUMS},
    '{64'd1,                   1'b1, 1'b1, SQUARES},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, ZERO_SUMS},
    '{64'h8000_0000_0000_0000, 1'b1, 1'b0, ZERO_SUMS},
    '{64'd1,                   1'b0, 1'b0, ZERO_SUMS},
    '{64'h8000_0000_0000_0000, 1'b0, 1'b0, ZERO_SUMS},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, ZERO_SUMS},
    '{64'h5555_5555_5555_5555, 1'b0, 1'b0, ZERO_SUMS},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, ZERO_SUMS},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, ZERO_SUMS},
    '{64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, ZERO_SUMS},
    '{64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, ZERO_SUMS},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, ZERO_SUMS},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, ZERO_SUMS},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, ZERO_SUMS},
    '{64'h0000_0000_0000_001B, 1'b1, 1'b0, ZERO_SUMS},
    // The sample is left open here and finished under the next polynomial.
    '{64'hC3A5_5A3C_0F0F_F0F0, 1'b0, 1'b0, ZERO_SUMS},
    '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, ZERO_SUMS}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [MAX_BITS-1:0]   in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [MAX_BITS-1:0]   cfg_data;

  logic [63:0] poly_low;
  logic [63:0] row_acc [ROW_CAP];
  logic [63:0] row_pow [ROW_CAP];
  row_sum_t    fresh_rows [ROW_CAP];
  int          fresh_count;
  row_sum_t    sums_due [$];

  int mismatches      = 0;
  bit tx_idle_on      = 1'b1;
  bit rx_idle_on      = 1'b1;
  int holds_requested = 0;
  int holds_served    = 0;

  gf2k_vandermonde_combiner #(
    .NUM_PARTIES(NUM_PARTIES),
    .THRESHOLD  (THRESHOLD),
    .FIELD_BITS (FIELD_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [63:0] field_mask();
    return ((64'd1 << (K - 1)) << 1) - 64'd1;
  endfunction

  function automatic logic [63:0] fold_into_field(logic [63:0] x);
    logic [63:0] poly;
    poly = poly_low & field_mask();
    for (int i = 63; i >= K; i--) begin
      if (x[i]) begin
        x[i] = 1'b0;
        x    = x ^ (poly << (i - K));
      end
    end
    return x & field_mask();
  endfunction

  function automatic logic [63:0] gf_product(logic [63:0] a, logic [63:0] b);
    logic [63:0] msk;
    logic [63:0] poly;
    logic [63:0] acc;
    logic        top;
    msk  = field_mask();
    poly = poly_low & msk;
    acc  = '0;
    a    = a & msk;
    b    = b & msk;
    for (int i = K; i > 0; i--) begin
      top = acc[K-1];
      acc = (acc << 1) & msk;
      if (top) acc = acc ^ poly;
      if (b[i-1]) acc = acc ^ a;
    end
    return acc;
  endfunction

  task automatic clear_rows();
    for (int j = 0; j < ROW_CAP; j++) begin
      row_acc[j] = '0;
      row_pow[j] = 64'(j + 1);
    end
  endtask

  // Folds one element into every row; a flagged element leaves its row sums in fresh_rows.
  task automatic absorb_share(input logic [63:0] share, input logic last);
    logic [63:0] s;
    logic [63:0] p;
    logic [63:0] c;
    s = share & field_mask();
    fresh_count = 0;
    for (int j = 0; j < ROWS; j++) begin
      p = fold_into_field(row_pow[j]);
      c = fold_into_field(64'(j + 1));
      row_acc[j] = row_acc[j] ^ gf_product(p, s);
      row_pow[j] = gf_product(p, c);
    end
    if (last) begin
      for (int j = 0; j < ROWS; j++) begin
        fresh_rows[j] = '{value: row_acc[j] & field_mask(), index: 5'(j),
                          last: (j + 1 == ROWS)};
      end
      fresh_count = ROWS;
      clear_rows();
    end
  endtask

  function automatic logic [63:0] pick_share();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_share(input logic [63:0] share, input logic last, input logic fixed,
                            input logic [4:0][63:0] sums);
    int gap;
    row_sum_t want;
    gap = (tx_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= share;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    absorb_share(share, last);
    for (int j = 0; j < fresh_count; j++) begin
      want = fresh_rows[j];
      if (fixed) want.value = sums[j];
      sums_due.insert(sums_due.size(), want);
    end
  endtask

  task automatic send_random_samples(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) send_share(pick_share(), i == len - 1, 1'b0, ZERO_SUMS);
      sent += len;
    end
  endtask

  // Lets every outstanding row and any unflagged element in flight clear the block.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (LANE_SLACK) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    poly_low = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    row_sum_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (sums_due.size() == 0) begin
        flag_mismatch("unexpected row item", out_tdata[63:0], '0);
      end else begin
        want = sums_due.pop_front();
        if (out_tdata[63:0] !== want.value) flag_mismatch("combo_value", out_tdata[63:0], want.value);
        if (out_tdata[68:64] !== want.index)
          flag_mismatch("combo_index", 64'(out_tdata[68:64]), 64'(want.index));
        if (out_tlast !== want.last) flag_mismatch("last_combo", 64'(out_tlast), 64'(want.last));
        if (out_tdata[71:69] !== 3'b000) flag_mismatch("tdata padding", 64'(out_tdata[71:69]), '0);
      end
    end
  end

  // Receiver: random stall bursts, a requested long hold-off, or steady acceptance.
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (holds_served != holds_requested) begin
        holds_served++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (rx_idle_on && out_tready && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    poly_low  = MOD_RESET;
    clear_rows();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[i]) send_share(PLAN[i].share, PLAN[i].last, PLAN[i].fixed, PLAN[i].sums);

    settle();
    write_modulus(64'd0);
    send_random_samples(25);

    settle();
    write_modulus('1);
    send_random_samples(15);

    // Back-to-back flagged elements against a receiver that holds off: the
    // row buffer and the lanes back up until the input stalls.
    tx_idle_on = 1'b0;
    holds_requested++;
    repeat (10) send_share(pick_share(), 1'b1, 1'b0, ZERO_SUMS);
    tx_idle_on = 1'b1;
    send_random_samples(20);

    settle();
    write_modulus({$urandom, $urandom});
    send_random_samples(25);

    settle();
    write_modulus(MOD_RESET);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random_samples(35);

    settle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
